[rtl/core/vnth_pkg.sv]
// vnth_pkg: widths, hash and divider constants, cosine weight tables
// for the value noise terrain height block. no dependencies.
`timescale 1ns / 1ps

package vnth_pkg;

  localparam int CoordW  = 24;
  localparam int HeightW = 18;
  localparam int AmpW    = 8;
  localparam int WtW     = 15;

  localparam logic [AmpW-1:0] AMP_RESET = 8'd100;

  // lattice hash
  localparam logic [31:0] HASH_MUL_X = 32'd1087;
  localparam logic [31:0] HASH_XOR_A = 32'd12271334;
  localparam logic [31:0] HASH_MUL_Z = 32'd2749;
  localparam logic [31:0] HASH_XOR_B = 32'd2323245;

  // h mod 2001 through floor(2^42 / 2001)
  localparam logic [31:0] NOISE_MOD   = 32'd2001;
  localparam logic [31:0] NOISE_RECIP = 32'd2197924293;
  localparam logic [12:0] NOISE_BIAS  = 13'd1000;

  // final scale 48000 * 2^22 = 375 * 2^29, rounded half away from zero
  localparam logic [56:0] ROUND_HALF = 57'd100663296000;
  localparam int          DivShift   = 29;
  localparam logic [26:0] DIV_ODD    = 27'd375;
  localparam logic [31:0] DIV_RECIP  = 32'd2932031007;

  typedef struct packed {
    logic [WtW-1:0] wx8;
    logic [WtW-1:0] wz8;
    logic [WtW-1:0] wx16;
    logic [WtW-1:0] wz16;
  } wts_t;

  // q0.15 weight (1 - cos(k*pi/p)) / 2, p = 8 when per16 is low, else 16
  function automatic logic [WtW-1:0] cos_wt(input logic per16, input logic [3:0] k);
    logic [3:0] idx;
    logic [WtW-1:0] w;
    idx = per16 ? k : {k[2:0], 1'b0};
    case (idx)
      4'd0:    w = 15'd0;
      4'd1:    w = 15'd315;
      4'd2:    w = 15'd1247;
      4'd3:    w = 15'd2761;
      4'd4:    w = 15'd4799;
      4'd5:    w = 15'd7282;
      4'd6:    w = 15'd10114;
      4'd7:    w = 15'd13188;
      4'd8:    w = 15'd16384;
      4'd9:    w = 15'd19580;
      4'd10:   w = 15'd22654;
      4'd11:   w = 15'd25486;
      4'd12:   w = 15'd27969;
      4'd13:   w = 15'd30007;
      4'd14:   w = 15'd31521;
      default: w = 15'd32453;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/vnth_if.sv]
// vnth_if: valid/ready channels for vertex beats and height beats
// depends on vnth_pkg for field widths
`timescale 1ns / 1ps

interface vnth_vertex_if;
  import vnth_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] vertex_x;
  logic signed [CoordW-1:0] vertex_z;
  logic signed [CoordW-1:0] tile_origin_x;
  logic signed [CoordW-1:0] tile_origin_z;

  modport source (output valid, vertex_x, vertex_z, tile_origin_x, tile_origin_z,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_z, tile_origin_x, tile_origin_z,
                  output ready);
endinterface

interface vnth_height_if;
  import vnth_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [HeightW-1:0] height_q8;

  modport source (output valid, height_q8, input ready);
  modport sink   (input valid, height_q8, output ready);
endinterface

[rtl/core/value_noise_terrain_height.sv]
// value_noise_terrain_height: 16-stage pipeline, two-octave value noise height
// depends on vnth_pkg and the channel interfaces in vnth_if.sv
//
//   channel   dir  handshake      payload
//   vertex    in   valid/ready    vertex_x, vertex_z, tile_origin_x, tile_origin_z
//   height    out  valid/ready    height_q8
//   cfg       in   cfg_we         cfg_wdata -> amplitude
//
// one vertex beat per cycle while the height channel is not stalled.
// the stages hold the 32 lattice hashes, each reduced mod 2001 through a
// reciprocal multiply and back-multiply over three stages, then smoothing, two blend
// multiply stages, octave sum, amplitude multiply and the rounding divide over four stages.
// rst clears the stage valid bits and sets amplitude to 100.
// each stage holds when it is full and the stage after it cannot take it,
// so bubbles close up and a stalled height beat holds the pipe behind it.
`timescale 1ns / 1ps

module value_noise_terrain_height (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [vnth_pkg::AmpW-1:0] cfg_wdata,
  vnth_vertex_if.sink              vertex,
  vnth_height_if.source            height
);
  import vnth_pkg::*;

  localparam int Stages = 16;

  logic [AmpW-1:0]   amplitude;
  logic [Stages:1]   vld;
  logic [Stages:1]   en;

  logic signed [24:0] s1, t1;
  logic signed [22:0] ix2 [2];
  logic signed [22:0] iz2 [2];
  wts_t               wp [2:9];
  logic [31:0]        xm3 [2][4];
  logic [31:0]        zm3 [2][4];
  logic [31:0]        h4 [2][16];
  logic [21:0]        q5 [2][16];
  logic [31:0]        h5 [2][16];
  logic [31:0]        p6 [2][16];
  logic [31:0]        h6 [2][16];
  logic signed [10:0] n7 [2][16];
  logic signed [15:0] s8 [2][4];
  logic signed [31:0] fa9 [2];
  logic signed [31:0] fb9 [2];
  logic signed [45:0] v10 [2];
  logic signed [47:0] sum11;
  logic signed [56:0] num12;
  logic               neg13, neg14, neg15;
  logic [26:0]        m13, m14, m15;
  logic [17:0]        q14, q15;
  logic [26:0]        p15;

  // stage enables, back to front
  always_comb begin
    en[Stages] = !vld[Stages] || height.ready;
    for (int k = Stages - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vertex.ready = en[1];
  assign height.valid = vld[Stages];

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMP_RESET;
      vld       <= '0;
    end else begin
      if (cfg_we) begin
        amplitude <= cfg_wdata;
      end
      if (en[1]) begin
        vld[1] <= vertex.valid;
      end
      for (int k = 2; k <= Stages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 2: cell index truncated toward zero, step magnitude to weight
  logic [24:0]        sm, tm;
  logic [24:0]        qx [2];
  logic [24:0]        qz [2];
  wts_t               w2;
  always_comb begin
    sm = s1[24] ? 25'(-s1) : 25'(s1);
    tm = t1[24] ? 25'(-t1) : 25'(t1);
    qx[0] = sm >> 3;
    qz[0] = tm >> 3;
    qx[1] = sm >> 4;
    qz[1] = tm >> 4;
    w2.wx8  = cos_wt(1'b0, {1'b0, sm[2:0]});
    w2.wz8  = cos_wt(1'b0, {1'b0, tm[2:0]});
    w2.wx16 = cos_wt(1'b1, sm[3:0]);
    w2.wz16 = cos_wt(1'b1, tm[3:0]);
  end

  // stage 7: remainder correction
  logic [31:0]        rem7 [2][16];
  logic [11:0]        r7 [2][16];
  logic signed [12:0] c7 [2][16];
  always_comb begin
    for (int o = 0; o < 2; o++) begin
      for (int i = 0; i < 16; i++) begin
        rem7[o][i] = h6[o][i] - p6[o][i];
        r7[o][i] = (rem7[o][i][11:0] >= NOISE_MOD[11:0]) ?
                   rem7[o][i][11:0] - NOISE_MOD[11:0] : rem7[o][i][11:0];
        c7[o][i] = $signed({1'b0, r7[o][i]}) - $signed(NOISE_BIAS);
      end
    end
  end

  // stage 8: 3x3 smoothing around the four cell corners, grid is [z][x]
  logic signed [15:0] sc8 [2][4];
  always_comb begin
    for (int o = 0; o < 2; o++) begin
      for (int cz = 0; cz < 2; cz++) begin
        for (int cx = 0; cx < 2; cx++) begin
          sc8[o][cz*2+cx] =
              (16'(n7[o][(cz+1)*4+cx+1]) <<< 2)
            + ((16'(n7[o][(cz+1)*4+cx]) + 16'(n7[o][(cz+1)*4+cx+2])
              + 16'(n7[o][cz*4+cx+1]) + 16'(n7[o][(cz+2)*4+cx+1])) <<< 1)
            + 16'(n7[o][cz*4+cx]) + 16'(n7[o][cz*4+cx+2])
            + 16'(n7[o][(cz+2)*4+cx]) + 16'(n7[o][(cz+2)*4+cx+2]);
        end
      end
    end
  end

  // stage 9: blend along x
  logic signed [16:0] da9 [2];
  logic signed [16:0] db9 [2];
  logic signed [31:0] pa9 [2];
  logic signed [31:0] pb9 [2];
  logic signed [15:0] wxs [2];
  always_comb begin
    wxs[0] = $signed({1'b0, wp[8].wx8});
    wxs[1] = $signed({1'b0, wp[8].wx16});
    for (int o = 0; o < 2; o++) begin
      da9[o] = 17'(s8[o][1]) - 17'(s8[o][0]);
      db9[o] = 17'(s8[o][3]) - 17'(s8[o][2]);
      pa9[o] = da9[o] * wxs[o];
      pb9[o] = db9[o] * wxs[o];
    end
  end

  // stage 10: blend along z
  logic signed [32:0] d10 [2];
  logic signed [48:0] pv10 [2];
  logic signed [15:0] wzs [2];
  always_comb begin
    wzs[0] = $signed({1'b0, wp[9].wz8});
    wzs[1] = $signed({1'b0, wp[9].wz16});
    for (int o = 0; o < 2; o++) begin
      d10[o]  = 33'(fb9[o]) - 33'(fa9[o]);
      pv10[o] = d10[o] * wzs[o];
    end
  end

  // stage 13: magnitude plus half divisor, low 29 bits of the dividend drop out
  logic [56:0] mag13, rnd13;
  always_comb begin
    mag13 = num12[56] ? 57'(-num12) : 57'(num12);
    rnd13 = mag13 + ROUND_HALF;
  end

  // stage 14/16: divide by 375 through reciprocal, one correction step
  logic [58:0] pq14;
  logic [26:0] r16;
  logic [17:0] qf16;
  always_comb begin
    pq14 = 59'(m13) * 59'(DIV_RECIP);
    r16  = m15 - p15;
    qf16 = (r16 >= DIV_ODD) ? q15 + 18'd1 : q15;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1 <= 25'(vertex.vertex_x) + 25'(vertex.tile_origin_x);
      t1 <= 25'(vertex.vertex_z) + 25'(vertex.tile_origin_z);
    end
    if (en[2]) begin
      for (int o = 0; o < 2; o++) begin
        ix2[o] <= s1[24] ? -$signed({1'b0, qx[o][21:0]}) : $signed({1'b0, qx[o][21:0]});
        iz2[o] <= t1[24] ? -$signed({1'b0, qz[o][21:0]}) : $signed({1'b0, qz[o][21:0]});
      end
      wp[2] <= w2;
    end
    for (int k = 3; k <= 9; k++) begin
      if (en[k]) begin
        wp[k] <= wp[k-1];
      end
    end
    // lattice columns ix-1..ix+2 and rows iz-1..iz+2
    if (en[3]) begin
      for (int o = 0; o < 2; o++) begin
        for (int c = 0; c < 4; c++) begin
          xm3[o][c] <= (32'(ix2[o]) + 32'(c) - 32'd1) * HASH_MUL_X;
          zm3[o][c] <= (32'(iz2[o]) + 32'(c) - 32'd1) * HASH_MUL_Z;
        end
      end
    end
    if (en[4]) begin
      for (int o = 0; o < 2; o++) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            h4[o][r*4+c] <= ((xm3[o][c] ^ HASH_XOR_A) + zm3[o][r]) ^ HASH_XOR_B;
          end
        end
      end
    end
    if (en[5]) begin
      for (int o = 0; o < 2; o++) begin
        for (int i = 0; i < 16; i++) begin
          q5[o][i] <= 22'((64'(h4[o][i]) * 64'(NOISE_RECIP)) >> 42);
          h5[o][i] <= h4[o][i];
        end
      end
    end
    if (en[6]) begin
      for (int o = 0; o < 2; o++) begin
        for (int i = 0; i < 16; i++) begin
          p6[o][i] <= 32'(q5[o][i]) * NOISE_MOD;
          h6[o][i] <= h5[o][i];
        end
      end
    end
    if (en[7]) begin
      for (int o = 0; o < 2; o++) begin
        for (int i = 0; i < 16; i++) begin
          n7[o][i] <= c7[o][i][10:0];
        end
      end
    end
    if (en[8]) begin
      s8 <= sc8;
    end
    if (en[9]) begin
      for (int o = 0; o < 2; o++) begin
        fa9[o] <= (32'(s8[o][0]) <<< 15) + pa9[o];
        fb9[o] <= (32'(s8[o][2]) <<< 15) + pb9[o];
      end
    end
    if (en[10]) begin
      for (int o = 0; o < 2; o++) begin
        v10[o] <= (46'(fa9[o]) <<< 15) + 46'(pv10[o]);
      end
    end
    if (en[11]) begin
      sum11 <= (48'(v10[0]) <<< 1) + 48'(v10[0]) + 48'(v10[1]);
    end
    if (en[12]) begin
      num12 <= 57'($signed({1'b0, amplitude})) * 57'(sum11);
    end
    if (en[13]) begin
      neg13 <= num12[56];
      m13   <= rnd13[DivShift+26:DivShift];
    end
    if (en[14]) begin
      neg14 <= neg13;
      m14   <= m13;
      q14   <= pq14[57:40];
    end
    if (en[15]) begin
      neg15 <= neg14;
      m15   <= m14;
      q15   <= q14;
      p15   <= 27'(q14) * DIV_ODD;
    end
    if (en[16]) begin
      height.height_q8 <= neg15 ? $signed(-qf16) : $signed(qf16);
    end
  end

endmodule
